// ===== rtl/core/emfd_pkg.sv =====
`timescale 1ns / 1ps

package emfd_pkg;

    // frame layout
    localparam logic [7:0] FRAME_HEADER = 8'h55;
    localparam int         FRAME_LEN    = 23;
    localparam int         CNT_W        = 5;
    localparam logic [CNT_W-1:0] CKSUM_IDX = CNT_W'(FRAME_LEN - 1);
    localparam logic [CNT_W-1:0] CUR_LO    = 5'd1;
    localparam logic [CNT_W-1:0] CUR_HI    = 5'd3;
    localparam logic [CNT_W-1:0] VOLT_LO   = 5'd4;
    localparam logic [CNT_W-1:0] VOLT_HI   = 5'd6;
    localparam logic [CNT_W-1:0] PWR_LO    = 5'd10;
    localparam logic [CNT_W-1:0] PWR_HI    = 5'd12;

    localparam int RAW_W = 24;

    // bit-serial multiplier: 32-bit multiplicand, 24-bit multiplier
    localparam int MCAND_W     = 32;
    localparam int MPLR_W      = 24;
    localparam int PROD_W      = MCAND_W + MPLR_W;
    localparam int MULT_STEPS  = MPLR_W;
    localparam int MULT_CNT_W  = $clog2(MULT_STEPS + 1);
    localparam int NUM_MULT    = 5;
    localparam int MUL_CUR     = 0;
    localparam int MUL_VOLT    = 1;
    localparam int MUL_PWR     = 2;
    localparam int MUL_DEN     = 3;
    localparam int MUL_NUM     = 4;

    // restoring divider for the power factor
    localparam int DIVISOR_W  = 2 * RAW_W;
    localparam int REM_W      = DIVISOR_W + 1;
    localparam int DIV_STEPS  = 15;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam int PF_W = 16;
    localparam logic [PF_W-1:0] PF_MAX = 16'h7FFF;
    localparam logic [31:0] INT32_MAX_C = 32'h7FFF_FFFF;
    localparam logic [31:0] INT32_MIN_C = 32'h8000_0000;

    // output beat: seven fields, 184 bits
    localparam int OUT_TDATA_W = 184;

    // configuration
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURRENT_GAIN  = 3'd0,
        CFG_VOLTAGE_GAIN  = 3'd1,
        CFG_POWER_GAIN    = 3'd2,
        CFG_PF_GAIN       = 3'd3,
        CFG_CHECKSUM_SEED = 3'd4
    } cfg_idx_t;

    localparam logic [31:0] CURRENT_GAIN_RST = 32'd66784828;
    localparam logic [31:0] VOLTAGE_GAIN_RST = 32'd1056278;
    localparam logic [31:0] POWER_GAIN_RST   = 32'd26912768;
    localparam logic [31:0] PF_GAIN_RST      = 32'd6400630;
    localparam logic [7:0]  SEED_RST         = 8'd88;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_DIV,
        ST_LOAD
    } dec_state_t;

    // end-of-frame event from the parser
    typedef struct packed {
        logic done;
        logic good;
    } frame_evt_t;

endpackage

// ===== rtl/core/emfd_frame_parser.sv =====
`timescale 1ns / 1ps

module emfd_frame_parser (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      beat_valid,
    input  logic [7:0]                rx_byte,
    input  logic [7:0]                seed,
    output emfd_pkg::frame_evt_t      evt,
    output logic [emfd_pkg::RAW_W-1:0] cur_raw,
    output logic [emfd_pkg::RAW_W-1:0] volt_raw,
    output logic [emfd_pkg::RAW_W-1:0] pwr_raw
);
    import emfd_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       sum_reg, sum_next;
    logic [RAW_W-1:0] cur_reg, cur_next;
    logic [RAW_W-1:0] volt_reg, volt_next;
    logic [RAW_W-1:0] pwr_reg, pwr_next;

    always_comb begin
        logic [1:0] lane;
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        cur_next  = cur_reg;
        volt_next = volt_reg;
        pwr_next  = pwr_reg;
        evt       = '0;
        lane      = '0;
        if (beat_valid) begin
            if (cnt_reg == '0) begin
                // hunting: drop everything but the header
                if (rx_byte == FRAME_HEADER) begin
                    sum_next  = seed + rx_byte;
                    cur_next  = '0;
                    volt_next = '0;
                    pwr_next  = '0;
                    cnt_next  = CNT_W'(1);
                end
            end else if (cnt_reg < CKSUM_IDX) begin
                sum_next = sum_reg + rx_byte;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg >= CUR_LO && cnt_reg <= CUR_HI) begin
                    lane = 2'(cnt_reg - CUR_LO);
                    cur_next[lane*8 +: 8] = rx_byte;
                end else if (cnt_reg >= VOLT_LO && cnt_reg <= VOLT_HI) begin
                    lane = 2'(cnt_reg - VOLT_LO);
                    volt_next[lane*8 +: 8] = rx_byte;
                end else if (cnt_reg >= PWR_LO && cnt_reg <= PWR_HI) begin
                    lane = 2'(cnt_reg - PWR_LO);
                    pwr_next[lane*8 +: 8] = rx_byte;
                end
            end else begin
                // checksum byte closes the frame
                cnt_next = '0;
                evt.done = 1'b1;
                evt.good = (~sum_reg == rx_byte);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            sum_reg  <= '0;
            cur_reg  <= '0;
            volt_reg <= '0;
            pwr_reg  <= '0;
        end else begin
            cnt_reg  <= cnt_next;
            sum_reg  <= sum_next;
            cur_reg  <= cur_next;
            volt_reg <= volt_next;
            pwr_reg  <= pwr_next;
        end
    end

    assign cur_raw  = cur_reg;
    assign volt_raw = volt_reg;
    assign pwr_raw  = pwr_reg;

endmodule

// ===== rtl/core/emfd_serial_mult.sv =====
`timescale 1ns / 1ps

module emfd_serial_mult (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [emfd_pkg::MCAND_W-1:0] mcand,
    input  logic [emfd_pkg::MPLR_W-1:0]  mplr,
    output logic                        busy,
    output logic [emfd_pkg::PROD_W-1:0]  prod
);
    import emfd_pkg::*;

    logic                  busy_reg, busy_next;
    logic [MULT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MCAND_W-1:0]    mcand_reg, mcand_next;
    logic [MCAND_W-1:0]    hi_reg, hi_next;
    logic [MPLR_W-1:0]     lo_reg, lo_next;
    logic [MCAND_W:0]      psum;

    // one multiplier bit per cycle, LSB first; the product shifts in from the top
    assign psum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    always_comb begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = MULT_CNT_W'(MULT_STEPS);
            mcand_next = mcand;
            hi_next    = '0;
            lo_next    = mplr;
        end else if (busy_reg) begin
            hi_next  = psum[MCAND_W:1];
            lo_next  = {psum[0], lo_reg[MPLR_W-1:1]};
            cnt_next = cnt_reg - MULT_CNT_W'(1);
            if (cnt_reg == MULT_CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign busy = busy_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

// ===== rtl/core/emfd_serial_div.sv =====
`timescale 1ns / 1ps

module emfd_serial_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [emfd_pkg::REM_W-1:0]     dividend,
    input  logic [emfd_pkg::DIVISOR_W-1:0] divisor,
    output logic                          busy,
    output logic [emfd_pkg::DIV_STEPS-1:0] quotient
);
    import emfd_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvsr_reg, dvsr_next;
    logic [DIV_STEPS-1:0] quo_reg, quo_next;
    logic                 ge;
    logic [REM_W-1:0]     diff;
    logic [REM_W-1:0]     kept;

    // dividend < 2*divisor on entry, so the partial remainder never
    // reaches twice the divisor and one quotient bit falls out per step
    assign ge   = rem_reg >= {1'b0, dvsr_reg};
    assign diff = rem_reg - {1'b0, dvsr_reg};
    assign kept = ge ? diff : rem_reg;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            rem_next  = dividend;
            dvsr_next = divisor;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = {kept[REM_W-2:0], 1'b0};
            quo_next = {quo_reg[DIV_STEPS-2:0], ge};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        quo_reg  <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/energy_meter_frame_decoder_unit.sv =====
// Energy meter frame decoder. Received serial bytes come in one per s_ beat;
// bytes are dropped until a 0x55 header, then 23 bytes (header through
// checksum) are collected at one beat per cycle. On the checksum beat a bad
// frame sends the sequencer to its load state, which gives a result beat with
// m_tuser = 1 and all of m_tdata zero. A good frame yields the raw current,
// voltage and power words, the three values scaled by their Q8.24 gains, and
// a Q2.14 power factor, passing through five bit-serial shift-add multipliers
// running side by side, a ratio check, the 15-step restoring divider for the
// power factor when needed, and a load. s_tready is low after the checksum
// beat until the result is loaded; other bytes are taken even while a result
// waits on m_tready. Gains and the checksum seed are written through
// cfg_wr_en, cfg_index and cfg_wdata; the user must write them only while the
// block is idle, which the block does not enforce. A new seed applies from
// the next header, and indexes past the last register are ignored.
`timescale 1ns / 1ps

module energy_meter_frame_decoder_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write port
    input  logic                                cfg_wr_en,
    input  logic [emfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [emfd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // byte stream in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
    // result stream out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [23:0] current_raw, [47:24] voltage_raw, [71:48] power_raw,
    // [103:72] current_ua, [135:104] voltage_mv, [167:136] power_mw,
    // [183:168] power_factor_q14
    output logic [emfd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic [0:0]                          m_tuser    // [0] frame_status
);
    import emfd_pkg::*;

    // config registers
    logic [31:0] cur_gain_reg;
    logic [31:0] volt_gain_reg;
    logic [31:0] pwr_gain_reg;
    logic [31:0] pf_gain_reg;
    logic [7:0]  seed_reg;

    // sequencer and output register
    dec_state_t            state_reg, state_next;
    logic                  bad_reg, bad_next;
    logic [PF_W-1:0]       pf_q_reg, pf_q_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [0:0]            m_tuser_reg, m_tuser_next;

    logic                  s_beat;
    frame_evt_t            frm_evt;
    logic [RAW_W-1:0]      cur_raw, volt_raw, pwr_raw;
    logic [RAW_W-1:0]      cur_mag, pwr_mag;

    logic                  mult_start;
    logic [NUM_MULT-1:0]   mult_busy;
    logic [MCAND_W-1:0]    mult_mcand [NUM_MULT];
    logic [MPLR_W-1:0]     mult_mplr  [NUM_MULT];
    logic [PROD_W-1:0]     mult_prod  [NUM_MULT];

    logic                  div_start;
    logic                  div_busy;
    logic [DIV_STEPS-1:0]  div_quo;

    logic [PROD_W-1:0]     pf_num;
    logic [DIVISOR_W-1:0]  pf_den;
    logic                  pf_over;
    logic                  out_free;

    // floor(x*g / 2^24) from the magnitude product; negative side rounds the
    // magnitude up, then both sides saturate to int32
    function automatic logic [31:0] scale_q24(input logic [PROD_W-1:0] prod,
                                              input logic neg);
        logic [31:0] mag;
        logic [31:0] mag_up;
        logic [31:0] res;
        mag    = prod[PROD_W-1:24];
        mag_up = mag + {31'b0, |prod[23:0]};
        if (neg) begin
            res = (mag_up > INT32_MIN_C) ? INT32_MIN_C : (~mag_up + 32'd1);
        end else begin
            res = mag[31] ? INT32_MAX_C : mag;
        end
        return res;
    endfunction

    //------------------------------------------------------------------
    // config writes
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_gain_reg  <= CURRENT_GAIN_RST;
            volt_gain_reg <= VOLTAGE_GAIN_RST;
            pwr_gain_reg  <= POWER_GAIN_RST;
            pf_gain_reg   <= PF_GAIN_RST;
            seed_reg      <= SEED_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CURRENT_GAIN:  cur_gain_reg  <= cfg_wdata;
                CFG_VOLTAGE_GAIN:  volt_gain_reg <= cfg_wdata;
                CFG_POWER_GAIN:    pwr_gain_reg  <= cfg_wdata;
                CFG_PF_GAIN:       pf_gain_reg   <= cfg_wdata;
                CFG_CHECKSUM_SEED: seed_reg      <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // byte parser
    //------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;

    emfd_frame_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (s_beat),
        .rx_byte    (s_tdata),
        .seed       (seed_reg),
        .evt        (frm_evt),
        .cur_raw    (cur_raw),
        .volt_raw   (volt_raw),
        .pwr_raw    (pwr_raw)
    );

    // magnitudes of the signed words; -2^23 maps to 2^23 unsigned
    assign cur_mag = cur_raw[RAW_W-1] ? (~cur_raw + RAW_W'(1)) : cur_raw;
    assign pwr_mag = pwr_raw[RAW_W-1] ? (~pwr_raw + RAW_W'(1)) : pwr_raw;

    //------------------------------------------------------------------
    // five bit-serial multipliers, all started together
    //------------------------------------------------------------------
    assign mult_mcand[MUL_CUR]  = cur_gain_reg;
    assign mult_mplr[MUL_CUR]   = cur_mag;
    assign mult_mcand[MUL_VOLT] = volt_gain_reg;
    assign mult_mplr[MUL_VOLT]  = volt_raw;
    assign mult_mcand[MUL_PWR]  = pwr_gain_reg;
    assign mult_mplr[MUL_PWR]   = pwr_mag;
    // power factor denominator |c|*v
    assign mult_mcand[MUL_DEN]  = {{(MCAND_W-RAW_W){1'b0}}, volt_raw};
    assign mult_mplr[MUL_DEN]   = cur_mag;
    // power factor numerator |p|*pf_gain
    assign mult_mcand[MUL_NUM]  = pf_gain_reg;
    assign mult_mplr[MUL_NUM]   = pwr_mag;

    for (genvar gi = 0; gi < NUM_MULT; gi++) begin : g_mult
        emfd_serial_mult u_mult (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (mult_start),
            .mcand   (mult_mcand[gi]),
            .mplr    (mult_mplr[gi]),
            .busy    (mult_busy[gi]),
            .prod    (mult_prod[gi])
        );
    end

    assign pf_num  = mult_prod[MUL_NUM];
    assign pf_den  = mult_prod[MUL_DEN][DIVISOR_W-1:0];
    // ratio of 2 or more saturates without dividing
    assign pf_over = {1'b0, pf_num} >= {{(PROD_W-DIVISOR_W){1'b0}}, pf_den, 1'b0};

    emfd_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (pf_num[REM_W-1:0]),
        .divisor  (pf_den),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    //------------------------------------------------------------------
    // sequencer
    //------------------------------------------------------------------
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        logic [PF_W-1:0] pf_out;
        logic            pf_neg;
        state_next    = state_reg;
        bad_next      = bad_reg;
        pf_q_next     = pf_q_reg;
        mult_start    = 1'b0;
        div_start     = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        pf_neg        = cur_raw[RAW_W-1] ^ pwr_raw[RAW_W-1];
        pf_out        = pf_neg ? (~pf_q_reg + PF_W'(1))
                               : (pf_q_reg[PF_W-1] ? PF_MAX : pf_q_reg);

        case (state_reg)
            ST_IDLE: begin
                if (frm_evt.done) begin
                    bad_next = !frm_evt.good;
                    if (frm_evt.good) begin
                        mult_start = 1'b1;
                        state_next = ST_MULT;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_MULT: begin
                if (mult_busy == '0) begin
                    if (pf_den == '0) begin
                        pf_q_next  = '0;
                        state_next = ST_LOAD;
                    end else if (pf_over) begin
                        pf_q_next  = PF_W'(1) << DIV_STEPS;
                        state_next = ST_LOAD;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (!div_busy) begin
                    pf_q_next  = {{(PF_W-DIV_STEPS){1'b0}}, div_quo};
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = bad_reg;
                    if (bad_reg) begin
                        m_tdata_next = '0;
                    end else begin
                        m_tdata_next = {pf_out,
                                        scale_q24(mult_prod[MUL_PWR], pwr_raw[RAW_W-1]),
                                        mult_prod[MUL_VOLT][PROD_W-1:24],
                                        scale_q24(mult_prod[MUL_CUR], cur_raw[RAW_W-1]),
                                        pwr_raw, volt_raw, cur_raw};
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bad_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            bad_reg      <= bad_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pf_q_reg    <= pf_q_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    //------------------------------------------------------------------
    // checks
    //------------------------------------------------------------------
    a_bad_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg[0] |-> m_tdata_reg == '0)
        else $error("bad frame beat carries nonzero data");

    a_mult_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        mult_busy != '0 |-> mult_busy == '1 && state_reg == ST_MULT)
        else $error("multipliers out of step or outside multiply phase");

    a_div_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> state_reg == ST_DIV)
        else $error("divider running outside divide phase");

    a_frame_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        frm_evt.done |-> state_reg == ST_IDLE)
        else $error("frame closed while a result is in flight");

    a_load_once: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOAD && out_free |=> state_reg == ST_IDLE && m_tvalid_reg)
        else $error("load did not present a result");

endmodule
